// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the vertex quadric accumulator.
// Each macro checks a property on the rising edge of clk, off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VQA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VQA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/vqa_pkg.sv -----
// Shared types and constants of the vertex quadric accumulator.
// No dependencies; every other file of the block but assert_macros.svh imports this package.
`timescale 1ns / 1ps
`default_nettype none

package vqa_pkg;

  // Channel widths.
  localparam int VQA_IN_W      = 184;
  localparam int VQA_SUM_W     = 64;
  localparam int VQA_NUM_TERMS = 10;
  localparam int VQA_OUT_W     = VQA_SUM_W * VQA_NUM_TERMS;

  // Vertex index limit and queue depth between front and back.
  localparam int VQA_MAX_VERTICES = 65536;
  localparam int VQA_QUEUE_DEPTH  = 2;

  // Classified face request as it waits in the queue.
  typedef struct packed {
    logic               hit;
    logic               last;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
  } vqa_item_t;

  // Status from the back end, seen by the queue and the top level.
  typedef struct packed {
    logic pop;
    logic emit;
  } vqa_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/vertex_quadric_accumulator.sv -----
// Vertex quadric accumulator: streams the faces of a mesh for one query vertex and
// returns the ten distinct terms of the summed plane quadric.
// Input: one face request per in_tvalid/in_tready handshake; in_tlast marks the last face
// of a pass. Output: one request of ten saturated 64-bit sums per pass, on the face
// marked last, after which the sums restart from zero.
// Schedule: a face that touches the query vertex occupies the back end for the multiply
// steps S_M1 to S_M4, set by the schedule of 13 products over four shared 32x32
// multipliers; a face that does not touch it skips them, and a last face also passes
// S_EMIT to load the result. A two-entry queue lets faces arrive while the back end works.
// Path: a matching last face goes through the queue, the four multiply steps and S_EMIT,
// which adds the last product and loads the output register behind out_tvalid; a
// non-matching last face goes from the queue straight to S_EMIT.
// Reset: the sums clear to zero, the queue empties and out_tvalid drops.
// Stall: a result waits in the output register while out_tready is low; the back end
// keeps working on following faces and only holds at the next last face, and the
// queue then backs up to in_tready.
// Depends on vqa_pkg, vqa_front, vqa_fifo, vqa_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vertex_quadric_accumulator
  import vqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = VQA_QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // query_vertex, corner_0, corner_1, corner_2, normal_x, normal_y, normal_z,
  // point_x, point_y, point_z
  input  wire logic [VQA_IN_W-1:0]  in_tdata,
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // sum_aa, sum_ab, sum_ac, sum_ad, sum_bb, sum_bc, sum_bd, sum_cc, sum_cd, sum_dd
  output logic [VQA_OUT_W-1:0]      out_tdata
);

  vqa_item_t push_item;
  vqa_item_t q_item;
  vqa_stat_t stat;
  logic      q_full;
  logic      q_push;
  logic      q_valid;

  // Classification of incoming faces.
  vqa_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Queue between front and back.
  vqa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (stat.pop),
    .pop_valid (q_valid),
    .pop_item  (q_item)
  );

  // Multiply, accumulate and emit.
  vqa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The back end never takes a face from an empty queue.
  `VQA_ASSERT_IMP(a_pop_nonempty, stat.pop, q_valid, "pop from empty queue")
  // A result is only loaded when the output register is free.
  `VQA_ASSERT_IMP(a_emit_free, stat.emit, (!out_tvalid || out_tready), "result overwritten")
  // A loaded result is offered in the next cycle.
  `VQA_ASSERT_NXT(a_emit_shows, stat.emit, out_tvalid, "emitted result not offered")

endmodule

`default_nettype wire

// ----- rtl/core/vqa_front.sv -----
// Front end: unpacks an input request and decides whether the face touches the query vertex.
// Depends on vqa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vqa_front
  import vqa_pkg::*;
(
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [VQA_IN_W-1:0] in_tdata,
  input  wire logic                in_tlast,
  input  wire logic                q_full,
  output logic                     q_push,
  output vqa_item_t                q_item
);

  localparam logic [24:0] MAX_VERT = 25'(VQA_MAX_VERTICES);

  logic [15:0] query;
  logic [15:0] corner0;
  logic [15:0] corner1;
  logic [15:0] corner2;
  logic        in_range;

  // Field extraction.
  assign query   = in_tdata[15:0];
  assign corner0 = in_tdata[31:16];
  assign corner1 = in_tdata[47:32];
  assign corner2 = in_tdata[63:48];

  // A face counts once if any corner is the query vertex.
  assign in_range = ({9'd0, query} < MAX_VERT);

  always_comb begin
    q_item.hit  = in_range && ((query == corner0) || (query == corner1) || (query == corner2));
    q_item.last = in_tlast;
    q_item.nx   = in_tdata[79:64];
    q_item.ny   = in_tdata[95:80];
    q_item.nz   = in_tdata[111:96];
    q_item.px   = in_tdata[135:112];
    q_item.py   = in_tdata[159:136];
    q_item.pz   = in_tdata[183:160];
  end

  // Requests enter the queue whenever it has room.
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule

`default_nettype wire

// ----- rtl/core/vqa_fifo.sv -----
// Short request queue between the front end and the back end.
// Depends on vqa_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module vqa_fifo
  import vqa_pkg::*;
#(
  parameter int DEPTH = VQA_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  vqa_item_t      push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           pop_valid,
  output vqa_item_t      pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vqa_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/vqa_back.sv -----
// Back end: four shared multipliers, plane offset rounding, saturating accumulators
// and the output register. Depends on vqa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vqa_back
  import vqa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  vqa_item_t                 q_item,
  output vqa_stat_t                 stat,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [VQA_OUT_W-1:0]      out_tdata
);

  localparam int NM = 4;

  // Term slots in output order.
  localparam logic [3:0] T_AA = 4'd0;
  localparam logic [3:0] T_AB = 4'd1;
  localparam logic [3:0] T_AC = 4'd2;
  localparam logic [3:0] T_AD = 4'd3;
  localparam logic [3:0] T_BB = 4'd4;
  localparam logic [3:0] T_BC = 4'd5;
  localparam logic [3:0] T_BD = 4'd6;
  localparam logic [3:0] T_CC = 4'd7;
  localparam logic [3:0] T_CD = 4'd8;
  localparam logic [3:0] T_DD = 4'd9;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_M1   = 6'b000010,
    S_M2   = 6'b000100,
    S_M3   = 6'b001000,
    S_M4   = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t                      state_r;
  state_t                      state_nxt;
  state_t                      prod_stage_r;
  vqa_item_t                   wk_r;
  logic signed [31:0]          d_r;
  logic signed [31:0]          d_nxt;
  logic signed [63:0]          prod_r     [NM];
  logic signed [63:0]          prod_nxt   [NM];
  logic signed [31:0]          mul_a      [NM];
  logic signed [31:0]          mul_b      [NM];
  logic signed [63:0]          sums_r     [VQA_NUM_TERMS];
  logic signed [63:0]          sums_nxt   [VQA_NUM_TERMS];
  logic signed [63:0]          addend     [VQA_NUM_TERMS];
  logic [VQA_NUM_TERMS-1:0]    add_en;
  logic signed [31:0]          a32;
  logic signed [31:0]          b32;
  logic signed [31:0]          c32;
  logic signed [31:0]          px32;
  logic signed [31:0]          py32;
  logic signed [31:0]          pz32;
  logic signed [43:0]          dot_sum;
  logic signed [43:0]          rnd;
  logic signed [43:0]          rnd_sh;
  logic [VQA_OUT_W-1:0]        out_data_r;
  logic                        out_valid_r;
  logic                        out_free;
  logic                        emit;
  logic                        take;

  // Saturating 64-bit signed add.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [63:0] s;
    s = x + y;
    if ((x[63] == y[63]) && (s[63] != x[63])) begin
      sat_add = x[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add = s;
    end
  endfunction

  // Sequencer control: a face is taken from the queue when the previous one is done.
  assign out_free = !out_valid_r || out_tready;
  assign emit     = (state_r == S_EMIT) && out_free;
  assign take     = q_valid && ((state_r == S_IDLE) ||
                                ((state_r == S_M4) && !wk_r.last) || emit);

  always_comb begin
    case (state_r)
      S_IDLE:  state_nxt = S_IDLE;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = wk_r.last ? S_EMIT : S_IDLE;
      S_EMIT:  state_nxt = emit ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
    if (take) begin
      state_nxt = q_item.hit ? S_M1 : (q_item.last ? S_EMIT : S_IDLE);
    end
  end

  // Sign-extended operands of the current face.
  assign a32  = {{16{wk_r.nx[15]}}, wk_r.nx};
  assign b32  = {{16{wk_r.ny[15]}}, wk_r.ny};
  assign c32  = {{16{wk_r.nz[15]}}, wk_r.nz};
  assign px32 = {{8{wk_r.px[23]}}, wk_r.px};
  assign py32 = {{8{wk_r.py[23]}}, wk_r.py};
  assign pz32 = {{8{wk_r.pz[23]}}, wk_r.pz};

  // Operand routing for the four multipliers, one schedule step per state.
  always_comb begin
    for (int k = 0; k < NM; k++) begin
      mul_a[k] = '0;
      mul_b[k] = '0;
    end
    case (state_r)
      S_M1: begin
        mul_a[0] = a32;  mul_b[0] = px32;
        mul_a[1] = b32;  mul_b[1] = py32;
        mul_a[2] = c32;  mul_b[2] = pz32;
        mul_a[3] = a32;  mul_b[3] = a32;
      end
      S_M2: begin
        mul_a[0] = a32;  mul_b[0] = b32;
        mul_a[1] = a32;  mul_b[1] = c32;
        mul_a[2] = b32;  mul_b[2] = b32;
        mul_a[3] = b32;  mul_b[3] = c32;
      end
      S_M3: begin
        mul_a[0] = c32;  mul_b[0] = c32;
        mul_a[1] = a32;  mul_b[1] = d_r;
        mul_a[2] = b32;  mul_b[2] = d_r;
        mul_a[3] = c32;  mul_b[3] = d_r;
      end
      S_M4: begin
        mul_a[0] = d_r;  mul_b[0] = d_r;
      end
      default: begin
        mul_a[0] = '0;
      end
    endcase
    for (int k = 0; k < NM; k++) begin
      prod_nxt[k] = mul_a[k] * mul_b[k];
    end
  end

  // Plane offset: d = floor((8192 - n.p) / 2^14), from the registered dot products.
  always_comb begin
    dot_sum = prod_r[0][43:0] + prod_r[1][43:0] + prod_r[2][43:0];
    rnd     = 44'sd8192 - dot_sum;
    rnd_sh  = rnd >>> 14;
    d_nxt   = rnd_sh[31:0];
  end

  // Route the registered products to their accumulators.
  always_comb begin
    for (int t = 0; t < VQA_NUM_TERMS; t++) begin
      addend[t] = '0;
    end
    add_en = '0;
    case (prod_stage_r)
      S_M1: begin
        addend[T_AA] = prod_r[3];  add_en[T_AA] = 1'b1;
      end
      S_M2: begin
        addend[T_AB] = prod_r[0];  add_en[T_AB] = 1'b1;
        addend[T_AC] = prod_r[1];  add_en[T_AC] = 1'b1;
        addend[T_BB] = prod_r[2];  add_en[T_BB] = 1'b1;
        addend[T_BC] = prod_r[3];  add_en[T_BC] = 1'b1;
      end
      S_M3: begin
        addend[T_CC] = prod_r[0];  add_en[T_CC] = 1'b1;
        addend[T_AD] = prod_r[1];  add_en[T_AD] = 1'b1;
        addend[T_BD] = prod_r[2];  add_en[T_BD] = 1'b1;
        addend[T_CD] = prod_r[3];  add_en[T_CD] = 1'b1;
      end
      S_M4: begin
        addend[T_DD] = prod_r[0];  add_en[T_DD] = 1'b1;
      end
      default: begin
        add_en = '0;
      end
    endcase
    for (int t = 0; t < VQA_NUM_TERMS; t++) begin
      sums_nxt[t] = add_en[t] ? sat_add(sums_r[t], addend[t]) : sums_r[t];
    end
  end

  // Control and accumulator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prod_stage_r <= S_IDLE;
      out_valid_r  <= 1'b0;
      for (int t = 0; t < VQA_NUM_TERMS; t++) begin
        sums_r[t] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      prod_stage_r <= state_r;
      for (int t = 0; t < VQA_NUM_TERMS; t++) begin
        sums_r[t] <= emit ? '0 : sums_nxt[t];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NM; k++) begin
      prod_r[k] <= prod_nxt[k];
    end
    if (take) begin
      wk_r <= q_item;
    end
    if (prod_stage_r == S_M1) begin
      d_r <= d_nxt;
    end
    if (emit) begin
      for (int t = 0; t < VQA_NUM_TERMS; t++) begin
        out_data_r[VQA_SUM_W*t +: VQA_SUM_W] <= sums_nxt[t];
      end
    end
  end

  assign stat.pop   = take;
  assign stat.emit  = emit;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the vertex quadric accumulator.
// Face requests go in on the in_ stream and quadric sums come out on the out_ stream.
// Depends on vqa_pkg and the vertex_quadric_accumulator RTL.
`timescale 1ns / 1ps

module tb_top;
  import vqa_pkg::*;

  // One face request as the driver and the predictor see it.
  typedef struct {
    logic [15:0]        query;
    logic [15:0]        corner0;
    logic [15:0]        corner1;
    logic [15:0]        corner2;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic               last;
  } face_t;

  // Predicts the quadric sums and checks every result request against them.
  class quadric_scoreboard;
    logic signed [63:0] acc [VQA_NUM_TERMS];
    logic [VQA_OUT_W-1:0] pending_sums [$];
    string term_name [VQA_NUM_TERMS];
    int errors;

    function new();
      term_name = '{"sum_aa", "sum_ab", "sum_ac", "sum_ad", "sum_bb",
                    "sum_bc", "sum_bd", "sum_cc", "sum_cd", "sum_dd"};
      foreach (acc[i]) acc[i] = '0;
      errors = 0;
    endfunction

    // Folds one accepted face into the running sums; a last face queues the sums.
    function void note_face(face_t f);
      logic signed [63:0] a, b, c, d, dot;
      logic signed [63:0] term [VQA_NUM_TERMS];
      logic signed [64:0] s;
      logic [VQA_OUT_W-1:0] packed_sums;
      bit hit;
      hit = (f.query < VQA_MAX_VERTICES) &&
            (f.query == f.corner0 || f.query == f.corner1 || f.query == f.corner2);
      if (hit) begin
        a = f.nx;
        b = f.ny;
        c = f.nz;
        dot = a * 64'(f.px) + b * 64'(f.py) + c * 64'(f.pz);
        // Negate, then round half up from Q10.30 to Q16.16.
        d = (-dot + 64'sd8192) >>> 14;
        term = '{a * a, a * b, a * c, a * d, b * b, b * c, b * d, c * c, c * d, d * d};
        for (int i = 0; i < VQA_NUM_TERMS; i++) begin
          s = {acc[i][63], acc[i]} + {term[i][63], term[i]};
          if (s[64] != s[63]) begin
            acc[i] = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            acc[i] = s[63:0];
          end
        end
      end
      if (f.last) begin
        for (int i = 0; i < VQA_NUM_TERMS; i++) begin
          packed_sums[i*VQA_SUM_W +: VQA_SUM_W] = acc[i];
          acc[i] = '0;
        end
        pending_sums = {pending_sums, packed_sums};
      end
    endfunction

    // Compares one result request field by field with the oldest expected sums.
    function void check_sums(logic [VQA_OUT_W-1:0] actual);
      logic [VQA_OUT_W-1:0] want;
      logic signed [63:0] want_field, got_field;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result request, data %h", $time, actual);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      for (int i = 0; i < VQA_NUM_TERMS; i++) begin
        want_field = want[i*VQA_SUM_W +: VQA_SUM_W];
        got_field = actual[i*VQA_SUM_W +: VQA_SUM_W];
        if (got_field !== want_field) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, term_name[i],
                   want_field, got_field);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [VQA_IN_W-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [VQA_OUT_W-1:0] out_tdata;

  quadric_scoreboard sb = new();
  // When set, neither side idles.
  bit calm;
  int faces_sent;

  vertex_quadric_accumulator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic face_t make_face(logic [15:0] q, logic [15:0] c0, logic [15:0] c1,
                                      logic [15:0] c2, logic signed [15:0] nx,
                                      logic signed [15:0] ny, logic signed [15:0] nz,
                                      logic signed [23:0] px, logic signed [23:0] py,
                                      logic signed [23:0] pz, logic last);
    face_t f;
    f = '{q, c0, c1, c2, nx, ny, nz, px, py, pz, last};
    return f;
  endfunction

  // Normal component biased toward the extremes, zero and unit length.
  function automatic logic signed [15:0] pick_normal();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  // Position component biased toward the extremes and small values.
  function automatic logic signed [23:0] pick_point();
    case ($urandom_range(0, 7))
      0: return 24'sh800000;
      1: return 24'sh7fffff;
      2: return 24'sd0;
      3: return 24'($signed($urandom_range(0, 131071)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  // Random face; most faces touch the query vertex at one or more corners.
  function automatic face_t random_face(logic [15:0] q, logic last);
    face_t f;
    int mask;
    f = make_face(q, 16'($urandom), 16'($urandom), 16'($urandom), pick_normal(),
                  pick_normal(), pick_normal(), pick_point(), pick_point(), pick_point(),
                  last);
    if ($urandom_range(0, 9) < 7) begin
      mask = $urandom_range(1, 7);
      if (mask[0]) f.corner0 = q;
      if (mask[1]) f.corner1 = q;
      if (mask[2]) f.corner2 = q;
    end else if ($urandom_range(0, 1)) begin
      // Near miss: a corner one off the query index.
      f.corner1 = q ^ 16'd1;
    end
    return f;
  endfunction

  // Drives one face request and waits for the handshake.
  task automatic send_face(face_t f);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {f.pz, f.py, f.px, f.nz, f.ny, f.nx, f.corner2, f.corner1, f.corner0,
                 f.query};
    in_tlast <= f.last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_face(f);
    faces_sent++;
  endtask

  // Result side: stalls a random number of cycles before taking each result.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_sums(out_tdata);
  end

  // Main sequence: directed faces, then random passes.
  initial begin
    logic [15:0] q;
    int pass_len;
    calm = 1'b0;
    faces_sent = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme normals and points, a hit through each corner, repeated corners.
    send_face(make_face(16'd7, 16'd7, 16'd1, 16'd2, 16'sh8000, 16'sh8000, 16'sh8000,
                        24'sh800000, 24'sh800000, 24'sh800000, 1'b0));
    send_face(make_face(16'd7, 16'd3, 16'd7, 16'd4, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b0));
    send_face(make_face(16'd7, 16'd5, 16'd6, 16'd7, 16'sh8000, 16'sh7fff, 16'sd0,
                        24'sh7fffff, 24'sh800000, 24'sd0, 1'b0));
    send_face(make_face(16'd7, 16'd7, 16'd7, 16'd7, 16'sd16384, 16'sd0, 16'sd0,
                        24'sd65536, 24'sd0, 24'sd0, 1'b1));
    // A lone last face that misses: the sums come out as zero.
    send_face(make_face(16'd9, 16'd1, 16'd2, 16'd3, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                        24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1'b1));
    // Lowest and highest vertex indices.
    send_face(make_face(16'd0, 16'd0, 16'hffff, 16'hffff, 16'sd100, 16'sd200, -16'sd300,
                        24'sd5000, -24'sd7000, 24'sd9000, 1'b0));
    send_face(make_face(16'd0, 16'hffff, 16'hffff, 16'hfffe, 16'sd1, 16'sd1, 16'sd1,
                        24'sd1, 24'sd1, 24'sd1, 1'b1));
    send_face(make_face(16'hffff, 16'hfffe, 16'd0, 16'hffff, -16'sd16384, 16'sd16384,
                        16'sd0, 24'sh123456, -24'sh054321, 24'sd0, 1'b1));
    // Rounding of the offset: ties toward plus infinity, a tie that rounds to zero, tiny values.
    send_face(make_face(16'd42, 16'd42, 16'd0, 16'd1, 16'sd1, 16'sd0, 16'sd0,
                        24'sd8192, 24'sd0, 24'sd0, 1'b0));
    send_face(make_face(16'd42, 16'd0, 16'd42, 16'd1, 16'sd1, 16'sd0, 16'sd0,
                        -24'sd8192, 24'sd0, 24'sd0, 1'b0));
    send_face(make_face(16'd42, 16'd0, 16'd1, 16'd42, 16'sd0, 16'sd1, 16'sd0,
                        24'sd0, 24'sd24576, 24'sd0, 1'b0));
    send_face(make_face(16'd42, 16'd42, 16'd42, 16'd1, 16'sd0, 16'sd0, 16'sd1,
                        24'sd0, 24'sd0, -24'sd1, 1'b0));
    // A miss followed by a matching last face.
    send_face(make_face(16'd42, 16'd41, 16'd43, 16'd40, 16'sh7fff, 16'sh8000, 16'sh7fff,
                        24'sh7fffff, 24'sh800000, 24'sh7fffff, 1'b0));
    send_face(make_face(16'd42, 16'd1, 16'd42, 16'd42, 16'sh8000, 16'sh7fff, 16'sh8000,
                        24'sh800000, 24'sh7fffff, 24'sh7fffff, 1'b1));

    // Random passes of random length, some without any idling.
    while (faces_sent < 1740) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: q = 16'd0;
        1: q = 16'hffff;
        default: q = 16'($urandom);
      endcase
      pass_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      for (int i = 0; i < pass_len; i++) send_face(random_face(q, i == pass_len - 1));
    end

    calm = 1'b0;
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;

    while (sb.pending_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("vertex_quadric_accumulator regression: pass");
    end else begin
      $display("vertex_quadric_accumulator regression: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10ms;
    $display("vertex_quadric_accumulator regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/vqa_pkg.sv
rtl/core/vqa_front.sv
rtl/core/vqa_fifo.sv
rtl/core/vqa_back.sv
rtl/core/vertex_quadric_accumulator.sv
tb/tb_top.sv
